/* rtl/tvp_pkg.sv */
package tvp_pkg;

  localparam int unsigned N_TAGGED_DEF          = 4;
  localparam int unsigned BASE_INDEX_BITS_DEF   = 10;
  localparam int unsigned TAGGED_INDEX_BITS_DEF = 8;
  localparam int unsigned TAG_WIDTH_DEF         = 8;
  localparam int unsigned CHECKPOINTS_DEF       = 32;

  localparam int unsigned REQ_W  = 3;
  localparam int unsigned XLEN   = 64;
  localparam int unsigned CONF_W = 4;
  localparam int unsigned PROV_W = 3;
  localparam int unsigned SLOT_W = 5;
  localparam int unsigned HLEN_W = 12;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [REQ_W-1:0] REQ_PREDICT  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_TRAIN    = 3'd1;
  localparam logic [REQ_W-1:0] REQ_CKPT     = 3'd2;
  localparam logic [REQ_W-1:0] REQ_RESTORE  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_CLEAR    = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_CONF_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_HIST   = 1'b1;

  localparam logic [CONF_W-1:0] CONF_LIMIT_RST = 4'd3;
  localparam logic [CONF_W-1:0] MIN_HIST_RST   = 4'd2;

  localparam logic [PROV_W-1:0] PROV_NONE = 3'b111;

endpackage

/* rtl/tvp_req_if.sv */
interface tvp_req_if import tvp_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [REQ_W-1:0]        req_type;
  logic [XLEN-1:0]         pc;
  logic [XLEN-1:0]         commit_value;
  logic signed [PROV_W-1:0] provider_in;
  logic [XLEN-1:0]         history_snapshot;
  logic [SLOT_W-1:0]       branch_tag;
  logic                    taken;

  modport source (output valid, req_type, pc, commit_value, provider_in,
                  history_snapshot, branch_tag, taken, input ready);
  modport sink (input valid, req_type, pc, commit_value, provider_in,
                history_snapshot, branch_tag, taken, output ready);
endinterface

/* rtl/tvp_rsp_if.sv */
interface tvp_rsp_if import tvp_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     available;
  logic                     is_confident;
  logic [XLEN-1:0]          predicted_value;
  logic signed [PROV_W-1:0] provider_out;
  logic [XLEN-1:0]          history_now;

  modport source (output valid, available, is_confident, predicted_value,
                  provider_out, history_now, input ready);
  modport sink (input valid, available, is_confident, predicted_value,
                provider_out, history_now, output ready);
endinterface

/* rtl/tvp_cfg_if.sv */
interface tvp_cfg_if import tvp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CONF_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/tagged_value_predictor.sv */
// Tagged value predictor: one pc-indexed base table and N_TAGGED tagged
// tables indexed by pc XOR folded branch history. For each request (predict,
// train, checkpoint, restore, clear) the transfer cycle issues reads to every
// table RAM; the execute state then resolves hits and writes back the updated
// entries once the response register is free, since each table RAM has a
// single read/write port. One response per request. A new request is taken
// while the previous response still waits on rsp_o. After reset the block
// runs a clearing pass over every address of the table RAMs with req_i.ready
// low; config writes are taken throughout. Config: index 0 conf_limit,
// index 1 min_history_length, 4 bits each.
module tagged_value_predictor import tvp_pkg::*; #(
  parameter int unsigned N_TAGGED          = N_TAGGED_DEF,
  parameter int unsigned BASE_INDEX_BITS   = BASE_INDEX_BITS_DEF,
  parameter int unsigned TAGGED_INDEX_BITS = TAGGED_INDEX_BITS_DEF,
  parameter int unsigned TAG_WIDTH         = TAG_WIDTH_DEF,
  parameter int unsigned CHECKPOINTS       = CHECKPOINTS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tvp_req_if.sink   req_i,
  tvp_rsp_if.source rsp_o,
  tvp_cfg_if.sink   cfg_i
);

  // entry layouts
  localparam int unsigned BASE_W = XLEN + CONF_W;
  localparam int unsigned TENT_W = 2 + TAG_WIDTH + CONF_W + XLEN;
  localparam int unsigned CLR_W  = ((BASE_INDEX_BITS > TAGGED_INDEX_BITS) ?
                                    BASE_INDEX_BITS : TAGGED_INDEX_BITS) + 1;
  localparam int unsigned CKPT_AW = (CHECKPOINTS > 1) ? $clog2(CHECKPOINTS) : 1;
  localparam int unsigned SLOTX_W = 9;
  localparam int unsigned TSEL_W  = (N_TAGGED > 1) ? $clog2(N_TAGGED) : 1;

  localparam logic [1:0] ST_CLR  = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_EX   = 2'd2;

  logic [1:0] state_q, state_d;
  logic [CLR_W-1:0] clr_cnt_q;

  logic [CONF_W-1:0] conf_lim_q, min_hist_q;

  // registered request
  logic [REQ_W-1:0]           req_q;
  logic [BASE_INDEX_BITS-1:0] bidx_q;
  logic [XLEN-1:0]            actual_q;
  logic [PROV_W-1:0]          prov_q;
  logic [SLOT_W-1:0]          slot_q;
  logic                       taken_q;
  logic [TAGGED_INDEX_BITS-1:0] tidx_q [N_TAGGED];
  logic [TAG_WIDTH-1:0]         ttag_q [N_TAGGED];
  logic [TAGGED_INDEX_BITS-1:0] tidx_h [N_TAGGED];
  logic [TAG_WIDTH-1:0]         ttag_h [N_TAGGED];

  logic [XLEN-1:0] hist_q, hist_d;
  logic [XLEN-1:0] ckpt_q [CHECKPOINTS];

  logic in_xfer, ex_go, clr;
  logic [XLEN-1:0] hash_hist;

  assign clr     = (state_q == ST_CLR);
  assign req_i.ready = (state_q == ST_IDLE);
  assign in_xfer = req_i.valid && req_i.ready;
  assign ex_go   = (state_q == ST_EX) && (!rsp_o.valid || rsp_o.ready);
  assign cfg_i.ready = 1'b1;

  // train hashes with the snapshot, everything else with live history
  assign hash_hist = (req_i.req_type == REQ_TRAIN) ? req_i.history_snapshot : hist_q;

  // base table
  logic              base_we;
  logic [BASE_W-1:0] base_rd, base_wd;
  logic [BASE_INDEX_BITS-1:0] base_addr;

  assign base_addr = clr ? clr_cnt_q[BASE_INDEX_BITS-1:0] :
                     (in_xfer ? req_i.pc[2 +: BASE_INDEX_BITS] : bidx_q);

  tvp_ram #(.WIDTH(BASE_W), .ADDR_W(BASE_INDEX_BITS)) u_base (
    .clk_i   (clk_i),
    .en_i    (clr || in_xfer || base_we),
    .we_i    (clr || base_we),
    .addr_i  (base_addr),
    .wdata_i (clr ? '0 : base_wd),
    .rdata_o (base_rd)
  );

  // tagged tables
  logic [TENT_W-1:0] t_rd [N_TAGGED];
  logic [TENT_W-1:0] t_wd [N_TAGGED];
  logic [N_TAGGED-1:0] t_we;

  for (genvar g = 0; g < N_TAGGED; g++) begin : g_tab
    logic [TAGGED_INDEX_BITS-1:0] addr;

    tvp_hash #(
      .TABLE(g), .TAGGED_INDEX_BITS(TAGGED_INDEX_BITS), .TAG_WIDTH(TAG_WIDTH)
    ) u_hash (
      .pc_i      (req_i.pc),
      .hist_i    (hash_hist),
      .min_len_i (min_hist_q),
      .idx_o     (tidx_h[g]),
      .tag_o     (ttag_h[g])
    );

    assign addr = clr ? clr_cnt_q[TAGGED_INDEX_BITS-1:0] :
                  (in_xfer ? tidx_h[g] : tidx_q[g]);

    tvp_ram #(.WIDTH(TENT_W), .ADDR_W(TAGGED_INDEX_BITS)) u_tab (
      .clk_i   (clk_i),
      .en_i    (clr || in_xfer || t_we[g]),
      .we_i    (clr || t_we[g]),
      .addr_i  (addr),
      .wdata_i (clr ? '0 : t_wd[g]),
      .rdata_o (t_rd[g])
    );
  end

  // resolve: hits, prediction, update and allocation
  logic                    is_train;
  logic [XLEN-1:0]         bval;
  logic [CONF_W-1:0]       bconf;
  logic [N_TAGGED-1:0]     hit;
  logic                    any_hit;
  logic                    p_avail, p_conf;
  logic [XLEN-1:0]         p_val;
  logic [PROV_W-1:0]       p_prov;
  logic                    al_found;
  logic [TSEL_W-1:0]       al_sel;

  assign is_train = ex_go && (req_q == REQ_TRAIN);
  assign bval  = base_rd[XLEN-1:0];
  assign bconf = base_rd[XLEN +: CONF_W];

  always_comb begin
    base_we = is_train;
    if (bval == actual_q) begin
      base_wd = {bconf + CONF_W'(bconf < conf_lim_q), bval};
    end else begin
      base_wd = {{CONF_W{1'b0}}, actual_q};
    end
  end

  always_comb begin
    logic              tv, tu;
    logic [TAG_WIDTH-1:0] tt;
    logic [CONF_W-1:0] tc;
    logic [XLEN-1:0]   tval;
    p_avail  = 1'b0;
    p_conf   = 1'b0;
    p_val    = '0;
    p_prov   = PROV_NONE;
    al_found = 1'b0;
    al_sel   = '0;
    // base fallback first; higher tables override
    if (bconf != '0) begin
      p_avail = 1'b1;
      p_conf  = bconf >= conf_lim_q;
      p_val   = bval;
    end
    for (int t = 0; t < N_TAGGED; t++) begin
      {tv, tu, tt, tc, tval} = t_rd[t];
      hit[t] = tv && (tt == ttag_q[t]);
      if (hit[t] && tc != '0) begin
        p_avail = 1'b1;
        p_conf  = tc >= conf_lim_q;
        p_val   = tval;
        p_prov  = PROV_W'(t);
      end
    end
    // lowest table with a replaceable entry
    for (int t = N_TAGGED - 1; t >= 0; t--) begin
      {tv, tu, tt, tc, tval} = t_rd[t];
      if (!tv || !tu) begin
        al_found = 1'b1;
        al_sel   = TSEL_W'(t);
      end
    end
  end

  assign any_hit = |hit;

  always_comb begin
    logic              tv, tu;
    logic [TAG_WIDTH-1:0] tt;
    logic [CONF_W-1:0] tc;
    logic [XLEN-1:0]   tval;
    for (int t = 0; t < N_TAGGED; t++) begin
      {tv, tu, tt, tc, tval} = t_rd[t];
      t_we[t] = 1'b0;
      t_wd[t] = t_rd[t];
      if (hit[t]) begin
        t_we[t] = is_train;
        if (tval == actual_q) begin
          tc = tc + CONF_W'(tc < conf_lim_q);
          if (!prov_q[PROV_W-1] && prov_q == PROV_W'(t)) begin
            tu = 1'b1;
          end
          t_wd[t] = {tv, tu, tt, tc, tval};
        end else begin
          t_wd[t] = {tv, 1'b0, tt, {CONF_W{1'b0}}, actual_q};
        end
      end else if (!any_hit && al_found && al_sel == TSEL_W'(t)) begin
        t_we[t] = is_train;
        t_wd[t] = {1'b1, 1'b0, ttag_q[t], {CONF_W{1'b0}}, actual_q};
      end
    end
  end

  // history update
  logic [SLOTX_W-1:0] slot_x;
  logic               slot_ok;
  logic [HLEN_W-1:0]  top_len;
  logic [XLEN-1:0]    top_mask;

  assign slot_x  = SLOTX_W'(slot_q);
  assign slot_ok = slot_x < SLOTX_W'(CHECKPOINTS);
  assign top_len = HLEN_W'(min_hist_q) << (N_TAGGED - 1);

  always_comb begin
    for (int i = 0; i < XLEN; i++) begin
      top_mask[i] = top_len > HLEN_W'(i);
    end
    hist_d = hist_q;
    case (req_q)
      REQ_CKPT:    hist_d = {hist_q[XLEN-2:0], taken_q} & top_mask;
      REQ_RESTORE: if (slot_ok) begin
        hist_d = ckpt_q[slot_x[CKPT_AW-1:0]];
      end
      REQ_CLEAR:   hist_d = '0;
      default:     hist_d = hist_q;
    endcase
  end

  // control
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLR:  if (clr_cnt_q[CLR_W-1]) begin
        state_d = ST_IDLE;
      end
      ST_IDLE: if (in_xfer) begin
        state_d = ST_EX;
      end
      ST_EX:   if (ex_go) begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLR;
      clr_cnt_q  <= '0;
      conf_lim_q <= CONF_LIMIT_RST;
      min_hist_q <= MIN_HIST_RST;
      hist_q     <= '0;
      rsp_o.valid <= 1'b0;
      for (int i = 0; i < CHECKPOINTS; i++) begin
        ckpt_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (clr && !clr_cnt_q[CLR_W-1]) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (cfg_i.valid) begin
        if (cfg_i.index == CFG_CONF_LIMIT) begin
          conf_lim_q <= cfg_i.data;
        end
        if (cfg_i.index == CFG_MIN_HIST) begin
          min_hist_q <= cfg_i.data;
        end
      end
      if (ex_go) begin
        hist_q <= hist_d;
        rsp_o.valid <= 1'b1;
        if (req_q == REQ_CKPT && slot_ok) begin
          ckpt_q[slot_x[CKPT_AW-1:0]] <= hist_q;
        end
        if (req_q == REQ_CLEAR) begin
          for (int i = 0; i < CHECKPOINTS; i++) begin
            ckpt_q[i] <= '0;
          end
        end
      end else if (rsp_o.ready) begin
        rsp_o.valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      req_q    <= req_i.req_type;
      bidx_q   <= req_i.pc[2 +: BASE_INDEX_BITS];
      actual_q <= req_i.commit_value;
      prov_q   <= req_i.provider_in;
      slot_q   <= req_i.branch_tag;
      taken_q  <= req_i.taken;
      for (int t = 0; t < N_TAGGED; t++) begin
        tidx_q[t] <= tidx_h[t];
        ttag_q[t] <= ttag_h[t];
      end
    end
    if (ex_go) begin
      rsp_o.history_now <= hist_d;
      if (req_q == REQ_PREDICT) begin
        rsp_o.available       <= p_avail;
        rsp_o.is_confident    <= p_conf;
        rsp_o.predicted_value <= p_val;
        rsp_o.provider_out    <= p_prov;
      end else begin
        rsp_o.available       <= 1'b0;
        rsp_o.is_confident    <= 1'b0;
        rsp_o.predicted_value <= '0;
        rsp_o.provider_out    <= PROV_NONE;
      end
    end
  end

endmodule

/* rtl/tvp_ram.sv */
module tvp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned ADDR_W = 8
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_o <= mem[addr_i];
      end
    end
  end

endmodule

/* rtl/tvp_hash.sv */
module tvp_hash import tvp_pkg::*; #(
  parameter int unsigned TABLE = 0,
  parameter int unsigned TAGGED_INDEX_BITS = TAGGED_INDEX_BITS_DEF,
  parameter int unsigned TAG_WIDTH = TAG_WIDTH_DEF
) (
  input  logic [XLEN-1:0]              pc_i,
  input  logic [XLEN-1:0]              hist_i,
  input  logic [CONF_W-1:0]            min_len_i,
  output logic [TAGGED_INDEX_BITS-1:0] idx_o,
  output logic [TAG_WIDTH-1:0]         tag_o
);

  logic [HLEN_W-1:0]            len;
  logic [XLEN-1:0]              hm;
  logic [TAGGED_INDEX_BITS-1:0] fi;
  logic [TAG_WIDTH-1:0]         ft;

  assign len = HLEN_W'(min_len_i) << TABLE;

  // history masked to this table's length, then folded
  always_comb begin
    fi = '0;
    ft = '0;
    for (int i = 0; i < XLEN; i++) begin
      hm[i] = hist_i[i] & (len > HLEN_W'(i));
    end
    for (int i = 0; i < XLEN; i++) begin
      fi[i % TAGGED_INDEX_BITS] = fi[i % TAGGED_INDEX_BITS] ^ hm[i];
      ft[i % TAG_WIDTH] = ft[i % TAG_WIDTH] ^ hm[i];
    end
  end

  assign idx_o = pc_i[2 +: TAGGED_INDEX_BITS] ^ fi;
  assign tag_o = pc_i[2 + TAGGED_INDEX_BITS +: TAG_WIDTH] ^ ft;

endmodule

/* bench/tvp_bench_if.sv */
`timescale 1ns / 100ps

// Bench-side copies of the channel interfaces are not needed: the RTL
// interfaces are instantiated directly. This file carries the request record
// of the driver queue and the response record of the expected-response store.
package tvp_bench_pkg;
  import tvp_pkg::*;

  typedef struct packed {
    logic [REQ_W-1:0]         req_type;
    logic [XLEN-1:0]          pc;
    logic [XLEN-1:0]          commit_value;
    logic signed [PROV_W-1:0] provider_in;
    logic [XLEN-1:0]          history_snapshot;
    logic [SLOT_W-1:0]        branch_tag;
    logic                     taken;
  } vp_req_t;

  typedef struct packed {
    logic                     available;
    logic                     is_confident;
    logic [XLEN-1:0]          predicted_value;
    logic signed [PROV_W-1:0] provider_out;
    logic [XLEN-1:0]          history_now;
  } vp_rsp_t;
endpackage

/* bench/tagged_value_predictor_test.sv */
`timescale 1ns / 100ps

module tagged_value_predictor_test;
  import tvp_pkg::*;
  import tvp_bench_pkg::*;

  localparam int NT   = N_TAGGED_DEF;
  localparam int BIB  = BASE_INDEX_BITS_DEF;
  localparam int TIB  = TAGGED_INDEX_BITS_DEF;
  localparam int TW   = TAG_WIDTH_DEF;
  localparam int NCKP = CHECKPOINTS_DEF;
  localparam int IDLE_LIMIT = 5000;   // watchdog limit; covers the clearing pass after reset

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  tvp_req_if req_ch ();
  tvp_rsp_if rsp_ch ();
  tvp_cfg_if cfg_ch ();

  tagged_value_predictor u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch.sink),
    .rsp_o  (rsp_ch.source),
    .cfg_i  (cfg_ch.sink)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---- predictor shadow state ----
  logic [CONF_W-1:0] sh_conf_limit;
  logic [CONF_W-1:0] sh_min_hist;
  logic [XLEN-1:0]   base_val [1<<BIB];
  logic [CONF_W-1:0] base_cnf [1<<BIB];
  logic              tg_vld [NT][1<<TIB];
  logic [TW-1:0]     tg_tag [NT][1<<TIB];
  logic [XLEN-1:0]   tg_val [NT][1<<TIB];
  logic [CONF_W-1:0] tg_cnf [NT][1<<TIB];
  logic              tg_use [NT][1<<TIB];
  logic [XLEN-1:0]   spec_hist;
  logic [XLEN-1:0]   ckpt_hist [NCKP];

  vp_req_t pending_reqs [$];
  vp_rsp_t expected_rsps [$];

  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int hold_sender     = 0;
  int mismatches      = 0;
  int rsp_seen        = 0;
  int req_sent        = 0;
  int req_driven      = 0;
  int idle_cycles     = 0;
  int kind_count [8];

  function automatic logic [XLEN-1:0] ones_below(int n);
    if (n >= 64) return '1;
    return (64'd1 << n) - 64'd1;
  endfunction

  function automatic int table_hist_bits(int t);
    return int'(sh_min_hist) << t;
  endfunction

  // Fold the masked history down to `w` bits by XOR of bit i onto i % w.
  function automatic logic [XLEN-1:0] fold_hist(logic [XLEN-1:0] h, int len, int w);
    logic [XLEN-1:0] acc;
    int n;
    acc = '0;
    n = (len > 64) ? 64 : len;
    for (int i = 0; i < n; i++)
      acc[i % w] = acc[i % w] ^ h[i];
    return acc & ones_below(w);
  endfunction

  function automatic int tagged_slot(logic [XLEN-1:0] pc, int t, logic [XLEN-1:0] h);
    int len;
    len = table_hist_bits(t);
    return int'(((pc >> 2) ^ fold_hist(h & ones_below(len), len, TIB)) & ones_below(TIB));
  endfunction

  function automatic logic [TW-1:0] tagged_key(logic [XLEN-1:0] pc, int t,
                                               logic [XLEN-1:0] h);
    int len;
    len = table_hist_bits(t);
    return TW'(((pc >> (2 + TIB)) ^ fold_hist(h & ones_below(len), len, TW))
               & ones_below(TW));
  endfunction

  task automatic clear_shadow();
    for (int i = 0; i < (1<<BIB); i++) begin
      base_val[i] = '0;
      base_cnf[i] = '0;
    end
    for (int t = 0; t < NT; t++)
      for (int i = 0; i < (1<<TIB); i++) begin
        tg_vld[t][i] = 1'b0;
        tg_tag[t][i] = '0;
        tg_val[t][i] = '0;
        tg_cnf[t][i] = '0;
        tg_use[t][i] = 1'b0;
      end
    spec_hist = '0;
    for (int i = 0; i < NCKP; i++) ckpt_hist[i] = '0;
    sh_conf_limit = CONF_LIMIT_RST;
    sh_min_hist   = MIN_HIST_RST;
  endtask

  // Apply one accepted request to the shadow state and return its response.
  function automatic vp_rsp_t predict_response(vp_req_t r);
    vp_rsp_t o;
    int b, ix;
    logic hit;
    logic [TW-1:0] key;
    o = '0;
    o.provider_out = PROV_NONE;
    b = int'((r.pc >> 2) & ones_below(BIB));
    case (r.req_type)
      REQ_PREDICT: begin
        for (int t = NT - 1; t >= 0; t--) begin
          ix = tagged_slot(r.pc, t, spec_hist);
          key = tagged_key(r.pc, t, spec_hist);
          if (!o.available && tg_vld[t][ix] && tg_tag[t][ix] == key && tg_cnf[t][ix] >= 1) begin
            o.available = 1'b1;
            o.predicted_value = tg_val[t][ix];
            o.is_confident = tg_cnf[t][ix] >= sh_conf_limit;
            o.provider_out = PROV_W'(t);
          end
        end
        if (!o.available && base_cnf[b] >= 1) begin
          o.available = 1'b1;
          o.predicted_value = base_val[b];
          o.is_confident = base_cnf[b] >= sh_conf_limit;
        end
      end
      REQ_TRAIN: begin
        hit = 1'b0;
        if (base_val[b] == r.commit_value) begin
          if (base_cnf[b] < sh_conf_limit) base_cnf[b]++;
        end else begin
          base_val[b] = r.commit_value;
          base_cnf[b] = '0;
        end
        for (int t = 0; t < NT; t++) begin
          ix = tagged_slot(r.pc, t, r.history_snapshot);
          key = tagged_key(r.pc, t, r.history_snapshot);
          if (tg_vld[t][ix] && tg_tag[t][ix] == key) begin
            hit = 1'b1;
            if (tg_val[t][ix] == r.commit_value) begin
              if (tg_cnf[t][ix] < sh_conf_limit) tg_cnf[t][ix]++;
              if (int'(r.provider_in) == t) tg_use[t][ix] = 1'b1;
            end else begin
              tg_val[t][ix] = r.commit_value;
              tg_cnf[t][ix] = '0;
              tg_use[t][ix] = 1'b0;
            end
          end
        end
        // No hit: allocate in the lowest table with a replaceable entry.
        if (!hit) begin
          for (int t = 0; t < NT; t++) begin
            ix = tagged_slot(r.pc, t, r.history_snapshot);
            if (!hit && (!tg_vld[t][ix] || !tg_use[t][ix])) begin
              hit = 1'b1;
              tg_vld[t][ix] = 1'b1;
              tg_tag[t][ix] = tagged_key(r.pc, t, r.history_snapshot);
              tg_val[t][ix] = r.commit_value;
              tg_cnf[t][ix] = '0;
              tg_use[t][ix] = 1'b0;
            end
          end
        end
      end
      REQ_CKPT: begin
        if (r.branch_tag < NCKP) ckpt_hist[r.branch_tag] = spec_hist;
        spec_hist = ((spec_hist << 1) | XLEN'(r.taken)) & ones_below(table_hist_bits(NT - 1));
      end
      REQ_RESTORE: begin
        if (r.branch_tag < NCKP) spec_hist = ckpt_hist[r.branch_tag];
      end
      REQ_CLEAR: begin
        spec_hist = '0;
        for (int i = 0; i < NCKP; i++) ckpt_hist[i] = '0;
      end
      default: ;  // unknown request types change nothing
    endcase
    o.history_now = spec_hist;
    return o;
  endfunction

  // ---- driver: present items at the falling edge ----
  initial begin
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_PREDICT;
    req_ch.pc = '0;
    req_ch.commit_value = '0;
    req_ch.provider_in = '0;
    req_ch.history_snapshot = '0;
    req_ch.branch_tag = '0;
    req_ch.taken = 1'b0;
    rsp_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_CONF_LIMIT;
    cfg_ch.data = '0;
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      // The item on the bus stays until the monitor has counted its transfer.
      if (!req_ch.valid || req_sent == req_driven) begin
        if (pending_reqs.size() > 0 && hold_sender == 0 &&
            $urandom_range(99) >= sender_idle_pct) begin
          vp_req_t nx;
          nx = pending_reqs.pop_front();
          req_ch.valid <= 1'b1;
          req_ch.req_type <= nx.req_type;
          req_ch.pc <= nx.pc;
          req_ch.commit_value <= nx.commit_value;
          req_ch.provider_in <= nx.provider_in;
          req_ch.history_snapshot <= nx.history_snapshot;
          req_ch.branch_tag <= nx.branch_tag;
          req_ch.taken <= nx.taken;
          req_driven++;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---- monitor: sample at the rising edge ----
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_ch.valid && req_ch.ready) begin
        vp_req_t acc;
        acc.req_type = req_ch.req_type;
        acc.pc = req_ch.pc;
        acc.commit_value = req_ch.commit_value;
        acc.provider_in = req_ch.provider_in;
        acc.history_snapshot = req_ch.history_snapshot;
        acc.branch_tag = req_ch.branch_tag;
        acc.taken = req_ch.taken;
        expected_rsps.push_back(predict_response(acc));
        kind_count[acc.req_type]++;
        req_sent++;
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == CFG_CONF_LIMIT) sh_conf_limit = cfg_ch.data;
        else sh_min_hist = cfg_ch.data;
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        rsp_seen++;
        if (expected_rsps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("ERROR: response with nothing expected");
        end else begin
          vp_rsp_t e;
          e = expected_rsps.pop_front();
          if (rsp_ch.available !== e.available || rsp_ch.is_confident !== e.is_confident ||
              rsp_ch.predicted_value !== e.predicted_value ||
              rsp_ch.provider_out !== e.provider_out ||
              rsp_ch.history_now !== e.history_now) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR rsp %0d: exp av=%b cf=%b val=%h prov=%0d hist=%h / got av=%b cf=%b val=%h prov=%0d hist=%h",
                       rsp_seen, e.available, e.is_confident, e.predicted_value,
                       e.provider_out, e.history_now, rsp_ch.available,
                       rsp_ch.is_confident, rsp_ch.predicted_value,
                       rsp_ch.provider_out, rsp_ch.history_now);
          end
        end
      end
      // Watchdog on transfers of any kind.
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("ERROR: no transfer for %0d cycles", IDLE_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // ---- stimulus helpers ----
  function automatic logic [XLEN-1:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic vp_req_t mk_req(logic [REQ_W-1:0] kind, logic [XLEN-1:0] pc,
                                     logic [XLEN-1:0] val, logic [XLEN-1:0] snap);
    vp_req_t r;
    r.req_type = kind;
    r.pc = pc;
    r.commit_value = val;
    r.provider_in = PROV_W'($urandom_range(7));
    r.history_snapshot = snap;
    r.branch_tag = SLOT_W'($urandom_range(31));
    r.taken = 1'($urandom_range(1));
    return r;
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || req_ch.valid || expected_rsps.size() > 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CONF_W-1:0] val);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  // Mixed sequence: a small pc pool is trained repeatedly with a history snapshot
  // from a small fixed pool and predicted, among checkpoints, restores, clears and odd requests.
  task automatic queue_random(int count);
    logic [XLEN-1:0] pcs [8];
    logic [XLEN-1:0] vals [8];
    logic [XLEN-1:0] hist_pool [4];
    int k;
    for (int i = 0; i < 8; i++) begin
      pcs[i] = ($urandom_range(3) == 0) ? rand64() : XLEN'($urandom_range(16'hffff));
      vals[i] = rand64();
    end
    for (int i = 0; i < 4; i++) hist_pool[i] = XLEN'($urandom_range(255));
    hist_pool[0] = '0;
    for (int n = 0; n < count; n++) begin
      k = $urandom_range(7);
      case ($urandom_range(19))
        0,1,2,3,4,5: pending_reqs.push_back(mk_req(REQ_TRAIN, pcs[k],
                      ($urandom_range(9) == 0) ? rand64() : vals[k],
                      hist_pool[$urandom_range(3)]));
        6,7,8,9,10,11: pending_reqs.push_back(mk_req(REQ_PREDICT, pcs[k], rand64(), rand64()));
        12,13: pending_reqs.push_back(mk_req(REQ_CKPT, rand64(), rand64(), rand64()));
        14: pending_reqs.push_back(mk_req(REQ_RESTORE, rand64(), rand64(), rand64()));
        15: pending_reqs.push_back(mk_req(REQ_CLEAR, rand64(), rand64(), rand64()));
        16: pending_reqs.push_back(mk_req(REQ_TRAIN, rand64(), rand64(), rand64()));
        17: pending_reqs.push_back(mk_req(REQ_PREDICT, rand64(), rand64(), rand64()));
        default: pending_reqs.push_back(mk_req(REQ_W'($urandom_range(7)), rand64(),
                                               rand64(), rand64()));
      endcase
    end
  endtask

  initial begin
    clear_shadow();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, every request type, special cases.
    pending_reqs.push_back(mk_req(REQ_PREDICT, '0, '0, '0));
    pending_reqs.push_back(mk_req(REQ_TRAIN, '1, '1, '1));
    pending_reqs.push_back(mk_req(REQ_TRAIN, '1, '1, '1));
    pending_reqs.push_back(mk_req(REQ_PREDICT, '1, '0, '0));
    pending_reqs.push_back(mk_req(REQ_TRAIN, 64'h40, 64'h1234, '0));
    pending_reqs.push_back(mk_req(REQ_TRAIN, 64'h40, 64'h1234, '0));
    pending_reqs.push_back(mk_req(REQ_PREDICT, 64'h40, '0, '0));
    for (int i = 0; i < 6; i++) begin
      vp_req_t c;
      c = mk_req(REQ_CKPT, '0, '0, '0);
      c.branch_tag = SLOT_W'(i == 5 ? 31 : i);
      c.taken = 1'(i % 2 == 0);
      pending_reqs.push_back(c);
    end
    pending_reqs.push_back(mk_req(REQ_PREDICT, 64'h40, '0, '0));
    begin
      vp_req_t c;
      c = mk_req(REQ_RESTORE, '0, '0, '0);
      c.branch_tag = 5'd2;
      pending_reqs.push_back(c);
    end
    pending_reqs.push_back(mk_req(REQ_CLEAR, '0, '0, '0));
    pending_reqs.push_back(mk_req(3'd5, '1, '1, '1));
    pending_reqs.push_back(mk_req(3'd7, '0, '0, '0));
    begin
      vp_req_t c;
      c = mk_req(REQ_TRAIN, 64'h40, 64'h1234, '0);
      c.provider_in = 3'sb100;  // names no table
      pending_reqs.push_back(c);
      c.provider_in = -3'sd1;
      pending_reqs.push_back(c);
    end
    wait_drained();

    // Phases over settings and idling patterns; sender pause is the drain.
    for (int ph = 0; ph < 6; ph++) begin
      logic [CONF_W-1:0] cl, mh;
      case (ph)
        0: begin cl = 4'd1;  mh = 4'd1; end
        1: begin cl = 4'd15; mh = 4'd8; end
        2: begin cl = 4'd3;  mh = 4'd0; end
        3: begin cl = 4'd2;  mh = 4'd15; end
        4: begin cl = 4'd0;  mh = 4'd4; end
        default: begin cl = 4'($urandom_range(1, 15)); mh = 4'($urandom_range(1, 8)); end
      endcase
      write_reg(CFG_CONF_LIMIT, cl);
      write_reg(CFG_MIN_HIST, mh);
      case (ph % 4)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 59; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 59; end
        default: begin sender_idle_pct = 35; recv_stall_pct = 35; end
      endcase
      queue_random(140);
      wait_drained();
    end

    $display("Covered %0d requests (predict %0d, train %0d, ckpt %0d, restore %0d, clear %0d)",
             req_sent, kind_count[0], kind_count[1], kind_count[2], kind_count[3],
             kind_count[4]);
    $display("over six register settings and four idle/stall mixes; %0d responses checked",
             rsp_seen);
    if (mismatches == 0 && expected_rsps.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

/* filelist.f */
rtl/tvp_pkg.sv
rtl/tvp_req_if.sv
rtl/tvp_rsp_if.sv
rtl/tvp_cfg_if.sv
rtl/tvp_ram.sv
rtl/tvp_hash.sv
rtl/tagged_value_predictor.sv
bench/tvp_bench_if.sv
bench/tagged_value_predictor_test.sv
